FILE: rtl/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// shared types and codes of the bidirectional pair table
// ----------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

	localparam int KEY_W   = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		CMD_ADD        = 2'd0,
		CMD_REMOVE     = 2'd1,
		CMD_GET_SECOND = 2'd2,
		CMD_GET_FIRST  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// operation held steady for the whole scan and commit
	typedef struct packed {
		cmd_t                     cmd;
		logic signed [KEY_W-1:0]  key_first;
		logic signed [KEY_W-1:0]  key_second;
	} op_t;

	// search record that walks the row of cells, one cell per cycle
	typedef struct packed {
		logic                     token;
		logic                     hit_first;
		logic                     hit_second;
		logic                     free_seen;
		logic signed [KEY_W-1:0]  partner;
	} probe_t;

	// table update broadcast to every cell after the scan
	typedef struct packed {
		logic add;
		logic del;
	} commit_t;

endpackage

`default_nettype wire

FILE: rtl/bpt_if.sv
// ----------------------------------------------------------------------------
// bpt_if
// request and response channels of the bidirectional pair table
// ----------------------------------------------------------------------------
`default_nettype none

interface bpt_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           cmd;
	logic signed [bpt_pkg::KEY_W-1:0]     key_first;
	logic signed [bpt_pkg::KEY_W-1:0]     key_second;

	modport source (output valid, output cmd, output key_first, output key_second,
		input ready);
	modport sink (input valid, input cmd, input key_first, input key_second,
		output ready);
endinterface

interface bpt_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           status;
	logic signed [bpt_pkg::KEY_W-1:0]     partner_value;
	logic [bpt_pkg::COUNT_W-1:0]          pair_count;

	modport source (output valid, output status, output partner_value,
		output pair_count, input ready);
	modport sink (input valid, input status, input partner_value,
		input pair_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/bpt_cell.sv
// ----------------------------------------------------------------------------
// bpt_cell
// one table slot: holds a pair, updates the passing search record
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bpt_pkg::op_t     op,
	input  wire bpt_pkg::commit_t commit,
	input  wire bpt_pkg::probe_t  probe_in,
	output bpt_pkg::probe_t       probe_out
);

	logic                                valid_q;
	logic                                sel_q;
	logic signed [bpt_pkg::KEY_W-1:0]    first_q;
	logic signed [bpt_pkg::KEY_W-1:0]    second_q;
	bpt_pkg::probe_t                     probe_q;
	bpt_pkg::probe_t                     probe_nxt;
	logic                                match_first;
	logic                                match_second;
	logic signed [bpt_pkg::KEY_W-1:0]    contrib;

	// stored keys only count while the slot is valid
	assign match_first  = valid_q && (first_q == op.key_first);
	assign match_second = valid_q && (second_q == op.key_second);

	always_comb begin
		contrib = '0;
		if (op.cmd == bpt_pkg::CMD_GET_SECOND && match_first) begin
			contrib = second_q;
		end else if (op.cmd == bpt_pkg::CMD_GET_FIRST && match_second) begin
			contrib = first_q;
		end
		probe_nxt            = probe_in;
		probe_nxt.hit_first  = probe_in.hit_first | match_first;
		probe_nxt.hit_second = probe_in.hit_second | match_second;
		probe_nxt.free_seen  = probe_in.free_seen | ~valid_q;
		probe_nxt.partner    = probe_in.partner | contrib;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
			probe_q <= '0;
		end else begin
			probe_q <= probe_nxt;
			// remember whether this slot is the one a commit would touch
			if (probe_in.token) begin
				if (op.cmd == bpt_pkg::CMD_ADD) begin
					sel_q <= ~valid_q & ~probe_in.free_seen;
				end else begin
					sel_q <= match_first;
				end
			end
			if (sel_q && commit.add) begin
				valid_q <= 1'b1;
			end else if (sel_q && commit.del) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel_q && commit.add) begin
			first_q  <= op.key_first;
			second_q <= op.key_second;
		end
	end

	assign probe_out = probe_q;

endmodule

`default_nettype wire

FILE: rtl/bidirectional_pair_table_core.sv
// ----------------------------------------------------------------------------
// bidirectional_pair_table_core
// fixed-capacity table of one-to-one pairs, searchable by either member
// ----------------------------------------------------------------------------
// The table is a row of CAPACITY cells, each holding one pair. An accepted item
// launches a search record into the first cell; the record moves one cell per
// cycle, collecting first-key and second-key matches, whether a free slot was
// seen, and the partner value for lookups. Each cell also notes whether it is
// the slot an update would touch (the matching slot for remove, the lowest free
// slot for add). The record that leaves the last cell is registered; once the
// output register is free, the controller forms the result and broadcasts the
// add or remove to the row, and the result then shows on rsp.valid. The walk
// through the cell row sets how long an item takes; one item is in flight at a
// time, and req.ready is high only while the block is idle. A finished result
// sits in an output register, so the next item is accepted while that result
// waits on rsp.ready; if it still waits when the next result is ready, that
// result holds until rsp.ready. Results come in acceptance order, one per item.
// pair_count reports the low five bits of the number of stored pairs after the
// operation.
// ----------------------------------------------------------------------------
`default_nettype none

module bidirectional_pair_table_core #(
	parameter int CAPACITY = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bpt_req_if.sink      req,
	bpt_rsp_if.source    rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int OUT_W = bpt_pkg::COUNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                              state_q;
	bpt_pkg::op_t                        op_q;
	logic                                start_q;
	bpt_pkg::probe_t                     fin_q;
	logic [CNT_W-1:0]                    count_q;
	logic                                rsp_valid_q;
	bpt_pkg::status_t                    status_q;
	logic signed [bpt_pkg::KEY_W-1:0]    partner_q;
	logic [OUT_W-1:0]                    pair_count_q;

	bpt_pkg::probe_t                     chain [CAPACITY+1];
	bpt_pkg::commit_t                    commit;

	logic                                req_fire;
	logic                                res_free;
	logic                                finish;
	bpt_pkg::status_t                    status_nxt;
	logic signed [bpt_pkg::KEY_W-1:0]    partner_nxt;
	logic [CNT_W-1:0]                    count_nxt;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign res_free  = !rsp_valid_q || rsp.ready;
	assign finish    = (state_q == S_DONE) && res_free;

	// the record entering the row starts empty
	always_comb begin
		chain[0]       = '0;
		chain[0].token = start_q;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bpt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op_q),
			.commit    (commit),
			.probe_in  (chain[i]),
			.probe_out (chain[i+1])
		);
	end

	// result and table update from the record that left the last cell
	always_comb begin
		status_nxt  = bpt_pkg::STAT_MISS;
		partner_nxt = '0;
		count_nxt   = count_q;
		commit      = '0;
		case (op_q.cmd)
			bpt_pkg::CMD_ADD: begin
				if (fin_q.hit_first || fin_q.hit_second) begin
					status_nxt = bpt_pkg::STAT_MISS;
				end else if (!fin_q.free_seen) begin
					status_nxt = bpt_pkg::STAT_FULL;
				end else begin
					status_nxt = bpt_pkg::STAT_OK;
					commit.add = finish;
					count_nxt  = CNT_W'(count_q + 1'b1);
				end
			end
			bpt_pkg::CMD_REMOVE: begin
				if (fin_q.hit_first) begin
					status_nxt = bpt_pkg::STAT_OK;
					commit.del = finish;
					count_nxt  = CNT_W'(count_q - 1'b1);
				end
			end
			bpt_pkg::CMD_GET_SECOND: begin
				if (fin_q.hit_first) begin
					status_nxt  = bpt_pkg::STAT_OK;
					partner_nxt = fin_q.partner;
				end
			end
			bpt_pkg::CMD_GET_FIRST: begin
				if (fin_q.hit_second) begin
					status_nxt  = bpt_pkg::STAT_OK;
					partner_nxt = fin_q.partner;
				end
			end
			default: begin
				status_nxt = bpt_pkg::STAT_MISS;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			start_q <= req_fire;
			// a new result replaces the one taken at this edge
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (chain[CAPACITY].token) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_free) begin
						count_q <= count_nxt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q.cmd        <= bpt_pkg::cmd_t'(req.cmd);
			op_q.key_first  <= req.key_first;
			op_q.key_second <= req.key_second;
		end
		if (state_q == S_SCAN && chain[CAPACITY].token) begin
			fin_q <= chain[CAPACITY];
		end
		if (finish) begin
			status_q     <= status_nxt;
			partner_q    <= partner_nxt;
			pair_count_q <= OUT_W'(count_nxt);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.partner_value = partner_q;
	assign rsp.pair_count    = pair_count_q;

endmodule

`default_nettype wire
